// File: rtl/core/base64_decoder_defines.svh
// Assertion macros shared by the base64 decoder checker.
// Depends on nothing; included by files that hold concurrent assertions.
`ifndef BASE64_DECODER_DEFINES_SVH
`define BASE64_DECODER_DEFINES_SVH

// Antecedent implies consequent in the same cycle.
`define B64D_ASSERT_SAME(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// Antecedent implies consequent in the next cycle.
`define B64D_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/core/b64d_pkg.sv
// Types, constants and the alphabet lookup of the base64 decoder.
// Depends on nothing; imported by every RTL module of the decoder.
`timescale 1ns / 1ps

package b64d_pkg;

    localparam logic [7:0] PAD_CHAR  = 8'h3D;
    localparam logic [6:0] NO_SEXTET = 7'd64;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_LENGTH   = 2'd1;
    localparam logic [1:0] ST_BAD_CHAR = 2'd2;
    localparam logic [1:0] ST_BAD_PAD  = 2'd3;

    // Results released by one character: up to three bytes packed
    // most significant first, a byte count, and the message close and status.
    typedef struct packed {
        logic [23:0] word;
        logic [1:0]  cnt;
        logic        done;
        logic [1:0]  status;
    } bundle_t;

    // Maps a character to its sextet, or NO_SEXTET outside the alphabet.
    function automatic logic [6:0] sextet_of(input logic [7:0] c);
        logic [6:0] s;
        s = NO_SEXTET;
        if (c inside {[8'h41:8'h5A]}) begin
            s = 7'(c - 8'h41);
        end else if (c inside {[8'h61:8'h7A]}) begin
            s = 7'(c - 8'h47);
        end else if (c inside {[8'h30:8'h39]}) begin
            s = 7'(c + 8'd4);
        end else if (c == 8'h2B) begin
            s = 7'd62;
        end else if (c == 8'h2F) begin
            s = 7'd63;
        end
        return s;
    endfunction

endpackage

// File: rtl/core/b64d_msg.sv
// Message state of the base64 decoder: group gathering, padding, errors
// and the byte limit. Depends on b64d_pkg.
`timescale 1ns / 1ps

module b64d_msg #(
    parameter int COUNT_BITS = 16
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              accept,
    input  logic [7:0]        char_code,
    input  logic              last_char,
    input  logic [15:0]       max_bytes,
    output b64d_pkg::bundle_t bundle
);
    import b64d_pkg::*;

    localparam int CMP_W = (COUNT_BITS > 16) ? COUNT_BITS : 16;

    logic [17:0]           acc_reg, acc_next;
    logic [1:0]            pos_reg, pos_next;
    logic [1:0]            pad_reg, pad_next;
    logic [COUNT_BITS-1:0] cnt_reg, cnt_next;
    logic [1:0]            err_reg, err_next;

    logic [CMP_W-1:0] lim;
    logic [CMP_W-1:0] cnt_ext;
    logic [CMP_W-1:0] remaining;
    logic             limited;
    logic [6:0]       sext;
    logic             bad;
    logic [1:0]       want;
    logic [1:0]       n;

    // The byte limit is the smaller of the register and the counter's top.
    assign lim = (CMP_W'(max_bytes) < CMP_W'({COUNT_BITS{1'b1}}))
               ? CMP_W'(max_bytes) : CMP_W'({COUNT_BITS{1'b1}});
    assign cnt_ext   = CMP_W'(cnt_reg);
    assign limited   = cnt_ext >= lim;
    assign remaining = lim - cnt_ext;
    assign sext      = sextet_of(char_code);

    always_comb begin
        acc_next = acc_reg;
        pad_next = pad_reg;
        cnt_next = cnt_reg;
        err_next = err_reg;
        bad      = 1'b0;
        want     = 2'd0;
        n        = 2'd0;
        bundle   = '0;

        if (!limited && err_reg == ST_OK) begin
            if (char_code == PAD_CHAR) begin
                if (pos_reg < 2'd2) begin
                    err_next = ST_BAD_PAD;
                    bad      = 1'b1;
                end else begin
                    pad_next = pad_reg + 2'd1;
                end
            end else if (sext == NO_SEXTET) begin
                err_next = ST_BAD_CHAR;
                bad      = 1'b1;
            end else if (pad_reg != 2'd0) begin
                err_next = ST_BAD_PAD;
                bad      = 1'b1;
            end

            if (!bad) begin
                if (pos_reg != 2'd3) begin
                    // A padded sextet enters as zero.
                    acc_next = {acc_reg[11:0],
                                (char_code == PAD_CHAR) ? 6'd0 : sext[5:0]};
                end else begin
                    bundle.word = {acc_reg,
                                   (char_code == PAD_CHAR) ? 6'd0 : sext[5:0]};
                    want = 2'd3 - pad_next;
                    n    = (CMP_W'(want) <= remaining) ? want : remaining[1:0];
                    cnt_next = cnt_reg + COUNT_BITS'(n);
                    acc_next = '0;
                    pad_next = '0;
                end
            end
        end

        pos_next   = pos_reg + 2'd1;
        bundle.cnt = n;

        if (last_char) begin
            bundle.done   = 1'b1;
            bundle.status = (pos_next != 2'd0) ? ST_LENGTH : err_next;
            acc_next = '0;
            pos_next = '0;
            pad_next = '0;
            cnt_next = '0;
            err_next = ST_OK;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg <= '0;
            pos_reg <= '0;
            pad_reg <= '0;
            cnt_reg <= '0;
            err_reg <= ST_OK;
        end
        else if (accept)
        begin
            acc_reg <= acc_next;
            pos_reg <= pos_next;
            pad_reg <= pad_next;
            cnt_reg <= cnt_next;
            err_reg <= err_next;
        end
    end

endmodule

// File: rtl/core/b64d_emit.sv
// Result stage of the base64 decoder: a result register that hands out the
// results of one character one beat at a time, with one holding slot behind
// it. Depends on b64d_pkg.
`timescale 1ns / 1ps

module b64d_emit (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              accept,
    input  b64d_pkg::bundle_t bundle,
    output logic              free,
    output logic              out_valid,
    input  logic              out_ready,
    output logic [7:0]        data_byte,
    output logic              byte_valid,
    output logic              done_res,
    output logic [1:0]        status,
    output logic              run_end
);
    import b64d_pkg::*;

    bundle_t    bun_reg, bun_next;
    bundle_t    pnd_reg, pnd_next;
    logic [1:0] idx_reg, idx_next;
    logic       full_reg, full_next;
    logic       pfull_reg, pfull_next;

    logic [1:0] last_idx;
    logic       last_beat;
    logic       take;
    logic       load;
    logic       slot_open;
    logic [7:0] sel_byte;

    // A close with no bytes still gives one beat.
    assign last_idx  = (bun_reg.cnt == 2'd0) ? 2'd0 : bun_reg.cnt - 2'd1;
    assign last_beat = idx_reg == last_idx;
    assign take      = full_reg && out_ready;
    // The result register can take a new set of results at this edge.
    assign slot_open = !full_reg || (take && last_beat);
    // The holding slot is only filled while the result register is busy.
    assign free      = !pfull_reg;
    assign load      = accept && (bundle.cnt != 2'd0 || bundle.done);

    always_comb
    begin
        case (idx_reg)
            2'd0:    sel_byte = bun_reg.word[23:16];
            2'd1:    sel_byte = bun_reg.word[15:8];
            default: sel_byte = bun_reg.word[7:0];
        endcase
    end

    assign out_valid  = full_reg;
    assign byte_valid = idx_reg < bun_reg.cnt;
    assign data_byte  = byte_valid ? sel_byte : 8'd0;
    assign run_end    = last_beat;
    assign done_res   = bun_reg.done && last_beat;
    assign status     = done_res ? bun_reg.status : ST_OK;

    always_comb
    begin
        bun_next   = bun_reg;
        pnd_next   = pnd_reg;
        idx_next   = idx_reg;
        full_next  = full_reg;
        pfull_next = pfull_reg;
        if (slot_open)
        begin
            idx_next = 2'd0;
            if (pfull_reg)
            begin
                // Held results go out before anything newer.
                bun_next   = pnd_reg;
                full_next  = 1'b1;
                pfull_next = 1'b0;
            end
            else if (load)
            begin
                bun_next  = bundle;
                full_next = 1'b1;
            end
            else
            begin
                full_next = 1'b0;
            end
        end
        else
        begin
            if (take)
            begin
                idx_next = idx_reg + 2'd1;
            end
            if (load)
            begin
                pnd_next   = bundle;
                pfull_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg   <= '0;
            full_reg  <= 1'b0;
            pfull_reg <= 1'b0;
        end
        else
        begin
            idx_reg   <= idx_next;
            full_reg  <= full_next;
            pfull_reg <= pfull_next;
        end
    end

    always_ff @(posedge clk)
    begin
        bun_reg <= bun_next;
        pnd_reg <= pnd_next;
    end

endmodule

// File: rtl/core/base64_decoder.sv
// Top level of the streaming base64 decoder.
// Depends on b64d_pkg, b64d_msg and b64d_emit.
`timescale 1ns / 1ps

// Usage
// The slave channel takes one character per beat: s_tdata is the character
// and s_tlast marks the final character of a message. The master channel
// gives decoded results: m_tdata[7:0] is the byte, m_tdata[9:8] the status,
// m_tdata[10] marks the last result caused by one character, m_tuser says
// that the byte is valid and m_tlast closes the message. The status is only
// nonzero on the closing beat; on an error the receiver drops the bytes it
// already took for that message.
// With the result register empty, the first result of a character is shown
// in the cycle after its beat. A character is taken in every cycle while the
// receiver keeps up: the up to three bytes of a group drain while the next
// group comes in. One holding slot sits behind the result register and
// s_tready drops only while it is occupied, which stalls the input when a
// message closes right after a three-byte group; a stall on m_tready backs
// up into s_tready once both are full. Reset clears all message state and
// sets the byte limit to 65535; no clearing pass is needed. The user must
// write the byte limit with cfg_we only while idle; the block does not check.

module base64_decoder #(
    parameter int COUNT_BITS = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [15:0] cfg_wdata,   // max_output_bytes
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,     // [7:0] char_code
    input  logic        s_tlast,     // last_char
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,     // [7:0] data_byte, [9:8] status, [10] run_end
    output logic        m_tlast,     // done_res
    output logic        m_tuser      // byte_valid
);
    import b64d_pkg::*;

    logic [15:0] max_reg;
    logic        accept;
    logic        free;
    bundle_t     bundle;
    logic [7:0]  data_byte;
    logic [1:0]  status;
    logic        run_end;

    // Byte limit register: user must write it only between messages; unenforced.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_reg <= 16'hFFFF;
        end
        else if (cfg_we)
        begin
            max_reg <= cfg_wdata;
        end
    end

    // A character enters when the holding slot has room for its results.
    assign s_tready = free;
    assign accept   = s_tvalid && s_tready;

    b64d_msg #(
        .COUNT_BITS (COUNT_BITS)
    ) u_msg (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (accept),
        .char_code (s_tdata),
        .last_char (s_tlast),
        .max_bytes (max_reg),
        .bundle    (bundle)
    );

    b64d_emit u_emit (
        .clk        (clk),
        .rst_n      (rst_n),
        .accept     (accept),
        .bundle     (bundle),
        .free       (free),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .data_byte  (data_byte),
        .byte_valid (m_tuser),
        .done_res   (m_tlast),
        .status     (status),
        .run_end    (run_end)
    );

    assign m_tdata = {5'd0, run_end, status, data_byte};

endmodule

// File: rtl/core/b64d_checker.sv
// Port-level checker for the base64 decoder, bound to the top level.
// Depends on base64_decoder_defines.svh and base64_decoder.
`timescale 1ns / 1ps
`include "base64_decoder_defines.svh"

module b64d_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [15:0] m_tdata,
    input logic        m_tlast,
    input logic        m_tuser
);

    // A stalled result stays offered and unchanged.
    `B64D_ASSERT_NEXT(a_hold, clk, rst_n, m_tvalid && !m_tready,
        m_tvalid && $stable(m_tdata) && $stable(m_tlast) && $stable(m_tuser),
        "result changed while stalled")

    // The closing result is always the last one of its character.
    `B64D_ASSERT_SAME(a_done_ends_run, clk, rst_n, m_tvalid && m_tlast,
        m_tdata[10], "close without run end")

    // A status appears only on the closing result.
    `B64D_ASSERT_SAME(a_status_on_close, clk, rst_n, m_tvalid && m_tdata[9:8] != 2'd0,
        m_tlast, "status off close")

    // A beat without a byte exists only to close a message.
    `B64D_ASSERT_SAME(a_empty_is_close, clk, rst_n, m_tvalid && !m_tuser,
        m_tlast && m_tdata[7:0] == 8'd0, "empty beat not a close")

    // The input waits only while results are queued for the output.
    `B64D_ASSERT_SAME(a_stall_needs_output, clk, rst_n, s_tvalid && !s_tready,
        m_tvalid, "input stalled with no result offered")

endmodule

bind base64_decoder b64d_checker u_b64d_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .m_tuser  (m_tuser)
);
